FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check on a clock with an active-low reset
`define CLT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent check that also holds while reset is asserted
`define CLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: src/clt_pkg.sv
package clt_pkg;

  localparam int CLT_LINE_MAX = 4096;
  localparam int MAXRES       = 4;
  localparam int QDEPTH       = 4;
  localparam int NWORDS       = 23;
  localparam int NKEYWORDS    = 14;

  localparam logic [3:0] K_SPACE    = 4'd0;
  localparam logic [3:0] K_KEYWORD  = 4'd1;
  localparam logic [3:0] K_LITERAL  = 4'd2;
  localparam logic [3:0] K_OPERATOR = 4'd3;
  localparam logic [3:0] K_PREPROC  = 4'd4;
  localparam logic [3:0] K_COMMENT  = 4'd5;
  localparam logic [3:0] K_IDENT    = 4'd6;
  localparam logic [3:0] K_FUNC     = 4'd7;
  localparam logic [3:0] K_TYPE     = 4'd8;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } in_t;

  typedef struct packed {
    logic [11:0] start_col;
    logic [11:0] token_len;
    logic [3:0]  token_kind;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    out_t [MAXRES-1:0] res;
    logic [2:0]        cnt;
  } grp_t;

  localparam logic [71:0] WORD_TEXT [NWORDS] = '{
    72'("if"), 72'("else"), 72'("for"), 72'("while"), 72'("return"), 72'("auto"),
    72'("const"), 72'("static"), 72'("class"), 72'("struct"), 72'("template"),
    72'("typename"), 72'("using"), 72'("namespace"), 72'("int"), 72'("void"),
    72'("float"), 72'("double"), 72'("char"), 72'("bool"), 72'("string"),
    72'("vector"), 72'("map")};

  localparam logic [3:0] WORD_SIZE [NWORDS] = '{
    4'd2, 4'd4, 4'd3, 4'd5, 4'd6, 4'd4, 4'd5, 4'd6, 4'd5, 4'd6, 4'd8, 4'd8,
    4'd5, 4'd9, 4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd4, 4'd6, 4'd6, 4'd3};

  function automatic logic [7:0] word_char(input int k, input logic [3:0] i);
    logic [71:0] w;
    int          sh;
    w  = WORD_TEXT[k];
    sh = 8 * (int'(WORD_SIZE[k]) - 1 - int'(i));
    if (sh < 0) sh = 0;
    return 8'(w >> sh);
  endfunction

endpackage

FILE: src/code_line_token_classifier_unit.sv
// channel   direction  ports                      payload
// input     in         in_push, in_full           in_data  (char_byte, end_of_line)
// result    out        out_pop, out_empty         out_data (start_col, token_len,
//                                                           token_kind, last_of_run)
// One byte is taken per cycle; its tokens (up to four) go to a four-entry group queue.
// Results leave one per cycle from the queue head while out_pop is high, so a byte
// giving n tokens yields n results; input stalls only when the group queue is full.
// Bytes giving no token never enter the queue. Reset is synchronous.
module code_line_token_classifier_unit #(
  parameter int LINE_MAX = clt_pkg::CLT_LINE_MAX
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  clt_pkg::in_t  in_data,
  input  logic          out_pop,
  output logic          out_empty,
  output clt_pkg::out_t out_data
);
  import clt_pkg::*;

  grp_t grp, head;
  logic acc, q_rd;

  assign acc = in_push && !in_full;

  clt_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .in_data(in_data), .grp(grp)
  );

  clt_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr(acc && grp.cnt != '0), .wr_data(grp),
    .rd(q_rd), .rd_data(head), .full(in_full), .empty(out_empty)
  );

  clt_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .q_empty(out_empty), .pop(out_pop),
    .q_rd(q_rd), .data(out_data)
  );

endmodule

FILE: src/clt_front.sv
module clt_front #(
  parameter int LINE_MAX = clt_pkg::CLT_LINE_MAX
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  clt_pkg::in_t  in_data,
  output clt_pkg::grp_t grp
);
  import clt_pkg::*;

  localparam int CAP_I = ((LINE_MAX - 1) < 4095) ? (LINE_MAX - 1) : 4095;
  localparam logic [11:0] CAP = 12'(CAP_I);
  localparam logic [NWORDS-1:0] ALL_WORDS = '1;

  typedef enum logic [2:0] {
    M_NORMAL, M_PREPROC, M_DQUOTE, M_SQUOTE, M_COMMENT
  } mode_t;

  typedef enum logic [3:0] {
    D_DEAD, D_START, D_ZERO, D_OCT, D_DEC, D_HEX0, D_HEX, D_BIN0, D_BIN,
    D_EXP0, D_EXP, D_SFX, D_SL, D_SLL
  } dfa_t;

  mode_t             mode_r, mode_nxt;
  dfa_t              dfa_r, dfa_nxt;
  logic              esc_r, esc_nxt, slp_r, slp_nxt, bsl_r, bsl_nxt;
  logic              wid_r, wid_nxt, hv_r, hv_nxt;
  logic [11:0]       col_r, col_nxt, ts_r, ts_nxt, clen_r, clen_nxt;
  logic [11:0]       hs_r, hs_nxt, hl_r, hl_nxt;
  logic [NWORDS-1:0] wmb_r, wmb_nxt;

  function automatic logic [11:0] sat(input logic [11:0] v);
    return (v < CAP) ? v + 12'd1 : CAP;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic dfa_t sfx(input logic [7:0] c);
    if (c == "u" || c == "U" || c == "f" || c == "F") return D_SFX;
    if (c == "l") return D_SL;
    if (c == "L") return D_SLL;
    return D_DEAD;
  endfunction

  function automatic dfa_t dfa_step(input dfa_t s, input logic [7:0] c);
    logic e;
    e = (c == "e" || c == "E");
    unique case (s)
      D_START: return (c == "0") ? D_ZERO : (is_digit(c) ? D_DEC : D_DEAD);
      D_ZERO: begin
        if (c == "x" || c == "X") return D_HEX0;
        if (c == "b" || c == "B") return D_BIN0;
        if (c >= "0" && c <= "7") return D_OCT;
        return e ? D_EXP0 : sfx(c);
      end
      D_OCT: begin
        if (c >= "0" && c <= "7") return D_OCT;
        return e ? D_EXP0 : sfx(c);
      end
      D_DEC: begin
        if (is_digit(c)) return D_DEC;
        return e ? D_EXP0 : sfx(c);
      end
      D_HEX0: return is_hex(c) ? D_HEX : D_DEAD;
      D_HEX:  return is_hex(c) ? D_HEX : sfx(c);
      D_BIN0: return (c == "0" || c == "1") ? D_BIN : D_DEAD;
      D_BIN: begin
        if (c == "0" || c == "1") return D_BIN;
        return e ? D_EXP0 : sfx(c);
      end
      D_EXP0: return is_digit(c) ? D_EXP : D_DEAD;
      D_EXP:  return is_digit(c) ? D_EXP : sfx(c);
      D_SL:   return (c == "l") ? D_SFX : D_DEAD;
      D_SLL:  return (c == "L") ? D_SFX : D_DEAD;
      default: return D_DEAD;
    endcase
  endfunction

  function automatic logic [3:0] word_kind(input dfa_t d, input logic [NWORDS-1:0] wm,
                                           input logic [11:0] len, input logic wid,
                                           input logic paren);
    logic [3:0] k;
    logic       hit;
    hit = 1'b0;
    k   = wid ? (paren ? K_FUNC : K_IDENT) : K_OPERATOR;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (wm[i] && len == 12'(WORD_SIZE[i])) begin
        hit = 1'b1;
        k   = (i < NKEYWORDS) ? K_KEYWORD : K_TYPE;
      end
    end
    if (d == D_ZERO || d == D_OCT || d == D_DEC || d == D_HEX || d == D_BIN ||
        d == D_EXP || d == D_SFX || d == D_SL || d == D_SLL) k = K_LITERAL;
    return k;
  endfunction

  function automatic void put(inout grp_t g, input logic [11:0] s, input logic [11:0] l,
                              input logic [3:0] k);
    if (g.cnt < 3'(MAXRES)) begin
      g.res[g.cnt[1:0]] = '{start_col: s, token_len: l, token_kind: k, last_of_run: 1'b0};
      g.cnt = g.cnt + 3'd1;
    end
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       eol, go, skip, sp, pn, wordb, paren;
    c = in_data.char_byte;
    eol = in_data.end_of_line;
    mode_nxt = mode_r; dfa_nxt = dfa_r; esc_nxt = esc_r; slp_nxt = slp_r;
    bsl_nxt = bsl_r; wid_nxt = wid_r; hv_nxt = hv_r; col_nxt = col_r;
    ts_nxt = ts_r; clen_nxt = clen_r; hs_nxt = hs_r; hl_nxt = hl_r; wmb_nxt = wmb_r;
    grp = '0;
    go = 1'b0;
    skip = 1'b0;
    sp = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    pn = (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
         (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    wordb = !(c == "#" || c == "/" || c == "\"" || c == "'" || sp || pn);
    paren = (c == "(");
    unique case (mode_r)
      M_COMMENT: clen_nxt = sat(clen_nxt);
      M_PREPROC: begin
        if (bsl_nxt) begin
          bsl_nxt = 1'b0;
          if (c == 8'd10) begin
            clen_nxt = sat(clen_nxt);
            skip = 1'b1;
          end
        end
        if (!skip) begin
          clen_nxt = sat(clen_nxt);
          if (c == "\\") begin
            bsl_nxt = 1'b1;
          end else if (sp) begin
            put(grp, ts_nxt, clen_nxt, K_PREPROC);
            mode_nxt = M_NORMAL;
            clen_nxt = '0;
          end
        end
      end
      M_DQUOTE, M_SQUOTE: begin
        clen_nxt = sat(clen_nxt);
        if (esc_nxt) begin
          esc_nxt = 1'b0;
        end else if (c == "\\") begin
          esc_nxt = 1'b1;
        end else if ((mode_r == M_DQUOTE && c == "\"") || (mode_r == M_SQUOTE && c == "'")) begin
          put(grp, ts_nxt, clen_nxt, K_LITERAL);
          mode_nxt = M_NORMAL;
          clen_nxt = '0;
        end
      end
      default: begin
        mode_nxt = M_NORMAL;
        go = 1'b1;
        if (slp_nxt) begin
          slp_nxt = 1'b0;
          if (c == "/") begin
            mode_nxt = M_COMMENT;
            clen_nxt = 12'd2;
            go = 1'b0;
          end else begin
            put(grp, ts_nxt, 12'd1, K_OPERATOR);
          end
        end
      end
    endcase

    if (go) begin
      if (!wordb || hv_nxt) begin
        if (hv_nxt) begin
          put(grp, hs_nxt, hl_nxt, paren ? K_FUNC : K_IDENT);
          hv_nxt = 1'b0;
        end
        if (clen_nxt != '0) begin
          put(grp, ts_nxt, clen_nxt, word_kind(dfa_nxt, wmb_nxt, clen_nxt, wid_nxt, paren));
          clen_nxt = '0;
        end
      end
      priority if (c == "#") begin
        mode_nxt = M_PREPROC;
        ts_nxt = col_r;
        clen_nxt = 12'd1;
        bsl_nxt = 1'b0;
      end else if (c == "/") begin
        if (eol) put(grp, col_r, 12'd1, K_OPERATOR);
        else begin
          slp_nxt = 1'b1;
          ts_nxt = col_r;
        end
      end else if (c == "\"" || c == "'") begin
        mode_nxt = (c == "\"") ? M_DQUOTE : M_SQUOTE;
        ts_nxt = col_r;
        clen_nxt = 12'd1;
        esc_nxt = 1'b0;
      end else if (sp) begin
        put(grp, col_r, 12'd1, (c == 8'd32 || c == 8'd9) ? K_SPACE : K_OPERATOR);
      end else if (pn) begin
        if (c == "_") begin
          hv_nxt = 1'b1;
          hs_nxt = col_r;
          hl_nxt = 12'd1;
        end else begin
          put(grp, col_r, 12'd1, K_OPERATOR);
        end
      end else begin
        if (clen_nxt == '0) begin
          ts_nxt = col_r;
          dfa_nxt = D_START;
          wmb_nxt = ALL_WORDS;
          wid_nxt = 1'b1;
        end
        for (int k = 0; k < NWORDS; k++) begin
          if (clen_nxt >= 12'(WORD_SIZE[k]) || word_char(k, clen_nxt[3:0]) != c)
            wmb_nxt[k] = 1'b0;
        end
        wid_nxt = wid_nxt && ((clen_nxt == '0) ? is_alpha(c) : (is_alpha(c) || is_digit(c)));
        dfa_nxt = dfa_step(dfa_nxt, c);
        clen_nxt = sat(clen_nxt);
      end
    end

    if (eol) begin
      if (mode_nxt == M_NORMAL) begin
        if (hv_nxt) put(grp, hs_nxt, hl_nxt, K_IDENT);
        if (clen_nxt != '0)
          put(grp, ts_nxt, clen_nxt, word_kind(dfa_nxt, wmb_nxt, clen_nxt, wid_nxt, 1'b0));
      end else if (clen_nxt != '0) begin
        put(grp, ts_nxt, clen_nxt, (mode_nxt == M_COMMENT) ? K_COMMENT :
            ((mode_nxt == M_PREPROC) ? K_PREPROC : K_LITERAL));
      end
      mode_nxt = M_NORMAL; esc_nxt = 1'b0; slp_nxt = 1'b0; bsl_nxt = 1'b0;
      col_nxt = '0; ts_nxt = '0; clen_nxt = '0; dfa_nxt = D_START;
      wmb_nxt = ALL_WORDS; wid_nxt = 1'b1; hv_nxt = 1'b0; hs_nxt = '0; hl_nxt = '0;
    end else begin
      col_nxt = sat(col_r);
    end

    if (grp.cnt != '0) grp.res[2'(grp.cnt - 3'd1)].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL; dfa_r <= D_START; esc_r <= 1'b0; slp_r <= 1'b0;
      bsl_r <= 1'b0; wid_r <= 1'b1; hv_r <= 1'b0; col_r <= '0; ts_r <= '0;
      clen_r <= '0; hs_r <= '0; hl_r <= '0; wmb_r <= ALL_WORDS;
    end else if (acc) begin
      mode_r <= mode_nxt; dfa_r <= dfa_nxt; esc_r <= esc_nxt; slp_r <= slp_nxt;
      bsl_r <= bsl_nxt; wid_r <= wid_nxt; hv_r <= hv_nxt; col_r <= col_nxt;
      ts_r <= ts_nxt; clen_r <= clen_nxt; hs_r <= hs_nxt; hl_r <= hl_nxt;
      wmb_r <= wmb_nxt;
    end
  end

endmodule

FILE: src/clt_queue.sv
`include "assert_macros.svh"
module clt_queue #(
  parameter int DEPTH = clt_pkg::QDEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  clt_pkg::grp_t wr_data,
  input  logic          rd,
  output clt_pkg::grp_t rd_data,
  output logic          full,
  output logic          empty
);
  import clt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + CW'(do_wr) - CW'(do_rd);
    end
  end

  `CLT_ASSERT_ALWAYS(a_cnt_bound, clk, (!rst_n || (cnt_r <= CW'(DEPTH))), "queue count above depth")
  `CLT_ASSERT(a_wr_grow, clk, rst_n, (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + CW'(1)), "write lost")
  `CLT_ASSERT(a_head_nonzero, clk, rst_n, !empty |-> (rd_data.cnt != '0), "empty group stored")

endmodule

FILE: src/clt_back.sv
module clt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  clt_pkg::grp_t head,
  input  logic          q_empty,
  input  logic          pop,
  output logic          q_rd,
  output clt_pkg::out_t data
);
  import clt_pkg::*;

  logic [1:0] idx_r;
  logic       take;

  assign take = pop && !q_empty;
  assign data = head.res[idx_r];
  assign q_rd = take && (3'(idx_r) == head.cnt - 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= q_rd ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
